// ----- design/assert_macros.svh -----
// assertion macros shared by the q15 gain merge certifier modules
// each macro expects a clock named clk and a reset named rst in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define Q15GM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// consequent must hold on the cycle after the antecedent
`define Q15GM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- design/q15gm_pkg.sv -----
// shared types, constants and the q15 round/saturate function
// no dependencies
package q15gm_pkg;

  localparam int GainW = 16;
  localparam int ProdW = 2 * GainW;
  localparam int FracW = 15;

  localparam logic signed [GainW-1:0] I16Max = 16'sh7FFF;
  localparam logic signed [GainW-1:0] I16Min = -16'sh8000;

  typedef logic signed [GainW-1:0] gain_t;
  typedef logic signed [ProdW-1:0] prod_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load;     // capture a new request
    logic merge;    // multiply inner by outer gain
    logic capture;  // store the rounded merged gain
    logic clear;    // reset sweep value and mismatch flag
    logic issue;    // push the current sweep value into the pipeline
    logic flush;    // drop anything still in flight
  } ctl_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic last_v;      // sweep value is the final one
    logic pipe_empty;  // no value in flight
    logic fail;        // a mismatch has been seen
  } dp_stat_t;

  // floor divide by 2^15, round with the selected tie rule, saturate to i16
  function automatic gain_t q15_round(input prod_t prod, input logic ties_up);
    logic [FracW-1:0] rem;
    logic signed [ProdW-FracW:0] q;
    logic up;
    logic signed [ProdW-FracW:0] qr;
    gain_t res;
    rem = prod[FracW-1:0];
    q = {prod[ProdW-1], prod[ProdW-1:FracW]};
    if (ties_up) begin
      up = rem[FracW-1];
    end else begin
      up = rem[FracW-1] & ((rem[FracW-2:0] != '0) | q[0]);
    end
    qr = q + $signed({{(ProdW-FracW){1'b0}}, up});
    if (qr > $signed({{(ProdW-FracW-GainW+1){1'b0}}, I16Max})) begin
      res = I16Max;
    end else if (qr < $signed({{(ProdW-FracW-GainW+1){1'b1}}, I16Min})) begin
      res = I16Min;
    end else begin
      res = qr[GainW-1:0];
    end
    return res;
  endfunction

endpackage

// ----- design/q15gm_ctrl.sv -----
// controller state machine for the q15 gain merge certifier
// depends on q15gm_pkg and assert_macros.svh
`include "assert_macros.svh"

module q15gm_ctrl import q15gm_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  dp_stat_t stat,
  output ctl_cmd_t cmd,
  output logic     busy,
  output logic     done
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MRG  = 3'd1;
  localparam logic [2:0] S_RND  = 3'd2;
  localparam logic [2:0] S_SWP  = 3'd3;
  localparam logic [2:0] S_DRN  = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  // next state and commands
  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          state_next = S_MRG;
        end
      end
      S_MRG: begin
        cmd.merge = 1'b1;
        cmd.clear = 1'b1;
        state_next = S_RND;
      end
      S_RND: begin
        cmd.capture = 1'b1;
        state_next = S_SWP;
      end
      S_SWP: begin
        if (stat.fail) begin
          state_next = S_DONE;
        end else begin
          cmd.issue = 1'b1;
          if (stat.last_v) state_next = S_DRN;
        end
      end
      S_DRN: begin
        if (stat.fail || stat.pipe_empty) state_next = S_DONE;
      end
      S_DONE: begin
        cmd.flush = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);
  assign done = (state == S_DONE);

  `Q15GM_ASSERT_NEXT(a_done_one_cycle, done, !done && !busy, "result strobe held or stuck busy")
  `Q15GM_ASSERT(a_issue_not_done, !(cmd.issue && (done || cmd.flush)), "issue during completion")
  `Q15GM_ASSERT_NEXT(a_accept_busy, start && !busy, busy && !done, "request not taken up")

endmodule

// ----- design/q15gm_dp.sv -----
// datapath: merged gain, sweep counter and compare pipeline
// depends on q15gm_pkg and assert_macros.svh
`include "assert_macros.svh"

module q15gm_dp import q15gm_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  ctl_cmd_t cmd,
  input  gain_t    first_gain,
  input  gain_t    second_gain,
  input  logic     tie_rule,
  output dp_stat_t stat,
  output gain_t    merged_gain,
  output logic     certified
);

  gain_t inner;
  gain_t outer;
  logic  ties_up;
  gain_t merged;
  gain_t v;

  prod_t p1;
  prod_t p3;
  gain_t a1;
  gain_t m3;
  prod_t p2;
  gain_t m3d;
  logic  vld1;
  logic  vld2;
  logic  vld3;
  logic  fail;

  gain_t mul_a;
  gain_t cascade;

  // request capture, merged gain and sweep value
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      inner   <= first_gain;
      outer   <= second_gain;
      ties_up <= tie_rule;
    end
    if (cmd.capture) merged <= q15_round(p1, ties_up);
    if (cmd.clear) begin
      v <= I16Min;
    end else if (cmd.issue) begin
      v <= v + 16'sd1;
    end
  end

  // first multiplier serves the merge step and then the inner gain stage
  assign mul_a = cmd.merge ? outer : v;

  // payload pipeline
  always_ff @(posedge clk) begin
    p1  <= prod_t'(mul_a) * prod_t'(inner);
    p3  <= prod_t'(v) * prod_t'(merged);
    a1  <= q15_round(p1, ties_up);
    m3  <= q15_round(p3, ties_up);
    p2  <= prod_t'(a1) * prod_t'(outer);
    m3d <= m3;
  end

  assign cascade = q15_round(p2, ties_up);

  // valid bits and sticky mismatch flag
  always_ff @(posedge clk) begin
    if (rst) begin
      vld1 <= 1'b0;
      vld2 <= 1'b0;
      vld3 <= 1'b0;
      fail <= 1'b0;
    end else begin
      vld1 <= cmd.issue;
      vld2 <= vld1 & ~cmd.flush;
      vld3 <= vld2 & ~cmd.flush;
      if (cmd.clear) begin
        fail <= 1'b0;
      end else if (vld3 && (cascade != m3d)) begin
        fail <= 1'b1;
      end
    end
  end

  assign stat.last_v     = (v == I16Max);
  assign stat.pipe_empty = ~(vld1 | vld2 | vld3);
  assign stat.fail       = fail;
  assign merged_gain     = merged;
  assign certified       = ~fail;

  `Q15GM_ASSERT_NEXT(a_fail_sticky, fail && !cmd.clear, fail, "mismatch flag dropped")
  `Q15GM_ASSERT_NEXT(a_flush_empties, cmd.flush && !cmd.issue, !vld2 && !vld3, "flush left data")

endmodule

// ----- design/q15_gain_merge_certifier.sv -----
// Q1.15 gain merge certifier: one request in, one result out after an exhaustive
// sweep. A request is taken at a rising edge with start high and busy low. When the
// merge holds, the steps are: form the merged gain product, round it, issue every
// i16 value into the compare pipeline, one per cycle, drain the pipeline and raise done
// for the result. busy drops in the cycle after done, so a new request is taken only
// after the previous result has been shown. A mismatch ends the sweep early: done is
// raised once the failing value has reached the compare and set the mismatch flag. The
// result is shown for exactly one cycle with done high; the receiver cannot stall it.
// depends on q15gm_pkg, q15gm_ctrl and q15gm_dp
module q15_gain_merge_certifier import q15gm_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] first_gain,
  input  logic signed [15:0] second_gain,
  input  logic               tie_rule,
  output logic               done,
  output logic signed [15:0] merged_gain,
  output logic               certified
);

  ctl_cmd_t cmd;
  dp_stat_t stat;

  // sequencing
  q15gm_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  // arithmetic and compare
  q15gm_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .first_gain  (first_gain),
    .second_gain (second_gain),
    .tie_rule    (tie_rule),
    .stat        (stat),
    .merged_gain (merged_gain),
    .certified   (certified)
  );

endmodule

// ----- tb/sv/gain_merge_checker.sv -----
`timescale 1ns / 100ps
// request/result checker for the q15 gain merge certifier: predicts merged gain and certificate
// depends on q15gm_pkg for the gain type
module gain_merge_checker import q15gm_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  input  logic  busy,
  input  gain_t first_gain,
  input  gain_t second_gain,
  input  logic  tie_rule,
  input  logic  done,
  input  gain_t merged_gain,
  input  logic  certified,
  output int    mismatches,
  output int    outstanding
);

  localparam longint QOne  = 32768;
  localparam longint QHalf = 16384;
  localparam longint SatHi = 32767;
  localparam longint SatLo = -32768;

  typedef struct packed {
    gain_t merged;
    logic  certified;
  } merge_verdict_t;

  merge_verdict_t verdict_q[$];

  // exact product, floor divide by 2^15, round with the tie rule, saturate
  function automatic gain_t apply_gain(input gain_t value, input gain_t gain, input logic ties_up);
    longint prod;
    longint quo;
    longint rem;
    prod = longint'(value) * longint'(gain);
    quo = prod >>> 15;
    rem = prod - quo * QOne;
    if (ties_up) begin
      if (rem >= QHalf) quo = quo + 1;
    end else if (rem > QHalf || (rem == QHalf && quo[0])) begin
      quo = quo + 1;
    end
    if (quo > SatHi) quo = SatHi;
    if (quo < SatLo) quo = SatLo;
    return gain_t'(quo[15:0]);
  endfunction

  // sweep every i16 value, stop at the first cascade/merge disagreement
  function automatic logic cascade_matches(input gain_t inner, input gain_t outer,
                                           input logic ties_up, input gain_t merged);
    int   i;
    gain_t v;
    for (i = -32768; i <= 32767; i++) begin
      v = gain_t'(i);
      if (apply_gain(apply_gain(v, inner, ties_up), outer, ties_up) !=
          apply_gain(v, merged, ties_up)) begin
        return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  initial begin
    mismatches = 0;
    outstanding = 0;
  end

  // retire results first, then predict the request taken at the same edge
  always @(posedge clk) begin : watch_channels
    merge_verdict_t due;
    merge_verdict_t fresh;
    if (rst) begin
      verdict_q.delete();
    end else begin
      if (done) begin
        if (verdict_q.size() == 0) begin
          mismatches = mismatches + 1;
          $display("%0t: result with no request pending, merged_gain %0d certified %0b",
                   $time, merged_gain, certified);
        end else begin
          due = verdict_q.pop_front();
          if (merged_gain !== due.merged) begin
            mismatches = mismatches + 1;
            $display("%0t: merged_gain expected %0d actual %0d",
                     $time, due.merged, merged_gain);
          end
          if (certified !== due.certified) begin
            mismatches = mismatches + 1;
            $display("%0t: certified expected %0b actual %0b",
                     $time, due.certified, certified);
          end
        end
      end
      if (start && !busy) begin
        fresh.merged = apply_gain(first_gain, second_gain, tie_rule);
        fresh.certified = cascade_matches(first_gain, second_gain, tie_rule, fresh.merged);
        verdict_q = {verdict_q, fresh};
      end
    end
    outstanding = verdict_q.size();
  end

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 100ps
// top of the q15 gain merge certifier bench: clock, reset, request stimulus and verdict
// depends on q15gm_pkg, q15_gain_merge_certifier and gain_merge_checker
module tb_top;
  import q15gm_pkg::*;

  localparam int StallLimit = 400000;

  logic  clk;
  logic  rst;
  logic  start;
  logic  busy;
  gain_t first_gain;
  gain_t second_gain;
  logic  tie_rule;
  logic  done;
  gain_t merged_gain;
  logic  certified;
  int    mismatches;
  int    outstanding;
  int    stall_cycles;
  int    n;

  q15_gain_merge_certifier u_dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .first_gain  (first_gain),
    .second_gain (second_gain),
    .tie_rule    (tie_rule),
    .done        (done),
    .merged_gain (merged_gain),
    .certified   (certified)
  );

  gain_merge_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .first_gain  (first_gain),
    .second_gain (second_gain),
    .tie_rule    (tie_rule),
    .done        (done),
    .merged_gain (merged_gain),
    .certified   (certified),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // raise start with the request fields, return at the falling edge after it is taken
  task automatic issue_request(input gain_t inner, input gain_t outer, input logic tie);
    logic taken;
    start <= 1'b1;
    first_gain <= inner;
    second_gain <= outer;
    tie_rule <= tie;
    taken = 1'b0;
    while (!taken) begin
      taken = !busy;
      @(negedge clk);
    end
  endtask

  // idle burst with junk on the fields, sometimes placed after the block goes idle
  task automatic sender_gap();
    int burst;
    burst = $urandom_range(1, 3);
    start <= 1'b0;
    first_gain <= gain_t'($urandom());
    second_gain <= gain_t'($urandom());
    tie_rule <= 1'($urandom_range(0, 1));
    @(negedge clk);
    if ($urandom_range(0, 1) == 1) begin
      while (busy) @(negedge clk);
    end
    repeat (burst - 1) begin
      first_gain <= gain_t'($urandom());
      @(negedge clk);
    end
  endtask

  // hold off until every pending request has reported
  task automatic drain_results();
    start <= 1'b0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
  endtask

  // gain mix: mostly full range, plus zero, rails, tiny and power-of-two gains
  function automatic gain_t random_gain();
    gain_t g;
    case ($urandom_range(0, 9))
      0: g = '0;
      1: g = I16Min;
      2: g = I16Max;
      3: g = gain_t'(int'($urandom_range(0, 8)) - 4);
      4: begin
        g = gain_t'(32'd1 << $urandom_range(0, 14));
        if ($urandom_range(0, 1) == 1) g = -g;
      end
      default: g = gain_t'($urandom());
    endcase
    return g;
  endfunction

  // stall watchdog: cycles with neither a request taken nor a result shown
  initial begin
    stall_cycles = 0;
    while (stall_cycles < StallLimit) begin
      @(posedge clk);
      if ((start && !busy) || done) stall_cycles = 0;
      else stall_cycles = stall_cycles + 1;
    end
    $display("tb_top: errors");
    $finish;
  end

  initial begin
    rst = 1'b1;
    start = 1'b0;
    first_gain = '0;
    second_gain = '0;
    tie_rule = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // zero gains always certify
    issue_request('0, '0, 1'b0);
    issue_request('0, I16Min, 1'b1);
    issue_request(I16Max, '0, 1'b0);
    // rails, including the only saturating product
    issue_request(I16Max, I16Max, 1'b0);
    issue_request(I16Max, I16Max, 1'b1);
    issue_request(I16Min, I16Min, 1'b0);
    issue_request(I16Min, I16Min, 1'b1);
    sender_gap();
    issue_request(I16Min, I16Max, 1'b1);
    issue_request(I16Max, I16Min, 1'b0);
    // exact ties on the merged gain, even and odd floor, both signs
    issue_request(16'sd16384, 16'sd1, 1'b0);
    issue_request(16'sd16384, 16'sd1, 1'b1);
    issue_request(16'sd16384, 16'sd3, 1'b0);
    issue_request(16'sd16384, 16'sd3, 1'b1);
    issue_request(-16'sd16384, 16'sd1, 1'b0);
    issue_request(-16'sd16384, 16'sd1, 1'b1);
    issue_request(-16'sd16384, -16'sd3, 1'b0);
    // unit steps and halves
    issue_request(16'sd1, 16'sd1, 1'b0);
    issue_request(-16'sd1, -16'sd1, 1'b1);
    issue_request(16'sd16384, 16'sd16384, 1'b0);
    issue_request(16'sd16384, -16'sd16384, 1'b1);
    drain_results();

    // random requests, idle bursts early, none in the last stretch
    for (n = 0; n < 100; n++) begin
      if (n == 40) drain_results();
      else if (n < 80 && $urandom_range(0, 2) == 0) sender_gap();
      issue_request(random_gain(), random_gain(), 1'($urandom_range(0, 1)));
    end

    drain_results();
    repeat (8) @(negedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+design
design/q15gm_pkg.sv
design/q15gm_ctrl.sv
design/q15gm_dp.sv
design/q15_gain_merge_certifier.sv
tb/sv/gain_merge_checker.sv
tb/sv/tb_top.sv
